// File: sv/i2dc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2dc_pkg: shared types and constants
// Request types, queue entry type and fixed-point constants for the
// 32-bit integer to decimal character converter.
// ----------------------------------------------------------------------------
package i2dc_pkg;

  localparam int NumDigits = 10;
  localparam int FracW     = 62;
  localparam int FixW      = 65;
  localparam int ProdW     = 61;

  localparam logic [6:0] CharMinus = 7'd45;
  localparam logic [6:0] CharZero  = 7'd48;

  // ceil(2^62 / 10^9) = 2^32 + RecipLo
  localparam logic [28:0] RecipLo = 29'd316718723;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        is_signed;
    logic [3:0]  min_digits;
  } in_req_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_req_t;

  typedef struct packed {
    logic [FixW-1:0] fix;
    logic            neg;
    logic [3:0]      prec;
  } work_t;

endpackage

// File: sv/int32_to_decimal_chars_core.sv
`timescale 1ns / 1ps
// path: a request passes the front stages, the queue and the sequencer before its
// sign or leading digit reaches the output register; each suppressed leading zero
// still takes a sequencer step; the sequencer walks all ten digit positions, one
// per cycle unless the output stalls, and takes the next number on the last digit
// reset: asynchronous, clears pipeline valids, queue pointers and sequencer state
// ----------------------------------------------------------------------------
// int32_to_decimal_chars_core: 32-bit integer to decimal ASCII characters
// Front scales the magnitude by 1/10^9, a short queue decouples it from the
// back end, which emits one character per request on the output channel.
// ----------------------------------------------------------------------------
module int32_to_decimal_chars_core #(
  parameter int QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  i2dc_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output i2dc_pkg::out_req_t out_req_o
);

  logic            push_valid, push_ready;
  i2dc_pkg::work_t push_data;
  logic            pop_valid, pop_ready;
  i2dc_pkg::work_t pop_data;

  i2dc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  i2dc_queue #(
    .Width ($bits(i2dc_pkg::work_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  i2dc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_data_i    (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

// File: sv/i2dc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2dc_front: request intake and scaling
// Takes sign and magnitude, clamps the digit count and scales the magnitude
// by the reciprocal of 10^9 into a fixed-point value with 62 fraction bits, in two stages.
// ----------------------------------------------------------------------------
module i2dc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  i2dc_pkg::in_req_t in_req_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output i2dc_pkg::work_t   push_data_o
);

  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_mag_q, s1_mag_d;
  logic        s1_neg_q, s1_neg_d;
  logic [3:0]  s1_prec_q, s1_prec_d;
  logic        s1_ready;

  logic                        s2_valid_q, s2_valid_d;
  logic [31:0]                 s2_mag_q;
  logic [i2dc_pkg::ProdW-1:0]  s2_prod_q, s2_prod_d;
  logic                        s2_neg_q;
  logic [3:0]                  s2_prec_q;
  logic                        s2_ready;

  logic s1_load, s2_load;

  assign s2_ready   = !s2_valid_q || push_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign s1_load    = in_valid_i && s1_ready;
  assign s2_load    = s1_valid_q && s2_ready;

  always_comb begin
    s1_neg_d  = in_req_i.is_signed && in_req_i.value_bits[31];
    s1_mag_d  = s1_neg_d ? (32'd0 - in_req_i.value_bits) : in_req_i.value_bits;
    s1_prec_d = (in_req_i.min_digits > 4'(i2dc_pkg::NumDigits)) ?
                4'(i2dc_pkg::NumDigits) : in_req_i.min_digits;
    s1_valid_d = s1_load ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_q);
    s2_valid_d = s2_load ? 1'b1 : (push_ready_i ? 1'b0 : s2_valid_q);
    s2_prod_d  = i2dc_pkg::ProdW'(s1_mag_q) * i2dc_pkg::ProdW'(i2dc_pkg::RecipLo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_mag_q  <= s1_mag_d;
      s1_neg_q  <= s1_neg_d;
      s1_prec_q <= s1_prec_d;
    end
    if (s2_load) begin
      s2_mag_q  <= s1_mag_q;
      s2_prod_q <= s2_prod_d;
      s2_neg_q  <= s1_neg_q;
      s2_prec_q <= s1_prec_q;
    end
  end

  // fix = mag * (2^32 + RecipLo), binary point at bit 62
  always_comb begin
    push_data_o.fix  = {1'b0, s2_mag_q, 32'd0} + i2dc_pkg::FixW'(s2_prod_q);
    push_data_o.neg  = s2_neg_q;
    push_data_o.prec = s2_prec_q;
  end

  assign push_valid_o = s2_valid_q;

endmodule

// File: sv/i2dc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2dc_queue: small request queue
// Flop-based FIFO between the scaling front and the digit back end.
// ----------------------------------------------------------------------------
module i2dc_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [IdxW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign wr_ready_o = cnt_q != CntW'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: sv/i2dc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2dc_back: digit sequencer
// Emits the sign, then one digit position per unstalled cycle, multiplying
// the fraction by ten, with leading-zero suppression and a registered output.
// ----------------------------------------------------------------------------
module i2dc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  i2dc_pkg::work_t    q_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output i2dc_pkg::out_req_t out_req_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSign  = 2'd1;
  localparam logic [1:0] StDigit = 2'd2;

  localparam int YW = i2dc_pkg::FracW + 4;

  logic [1:0]    state_q, state_d;
  logic [YW-1:0] y_q, y_d;
  logic [3:0]    pos_q, pos_d;
  logic          started_q, started_d;
  logic [3:0]    prec_q, prec_d;

  logic               out_valid_q, out_valid_d;
  i2dc_pkg::out_req_t out_req_q, out_req_d;

  logic                      advance, pad, last_pos, show, step_done, load, emit;
  logic [3:0]                digit;
  logic [i2dc_pkg::FracW-1:0] frac;
  logic [YW-1:0]             y_ten;

  assign advance   = !out_valid_q || out_ready_i;
  assign digit     = y_q[YW-1:i2dc_pkg::FracW];
  assign frac      = y_q[i2dc_pkg::FracW-1:0];
  assign y_ten     = ({4'd0, frac} << 3) + ({4'd0, frac} << 1);
  assign pad       = (5'(pos_q) + 5'(prec_q)) >= 5'(i2dc_pkg::NumDigits);
  assign last_pos  = pos_q == 4'(i2dc_pkg::NumDigits - 1);
  assign show      = (digit != 4'd0) || started_q || pad || last_pos;
  assign step_done = (state_q == StDigit) && advance && last_pos;
  assign q_ready_o = (state_q == StIdle) || step_done;
  assign load      = q_valid_i && q_ready_o;

  always_comb begin
    state_d   = state_q;
    y_d       = y_q;
    pos_d     = pos_q;
    started_d = started_q;
    prec_d    = prec_q;
    emit      = 1'b0;
    out_req_d = out_req_q;
    unique case (state_q)
      StIdle: begin
      end
      StSign: begin
        if (advance) begin
          emit                = 1'b1;
          out_req_d.char_code = i2dc_pkg::CharMinus;
          out_req_d.last_char = 1'b0;
          state_d             = StDigit;
        end
      end
      StDigit: begin
        if (advance) begin
          emit                = show;
          out_req_d.char_code = i2dc_pkg::CharZero + {3'd0, digit};
          out_req_d.last_char = last_pos;
          y_d                 = y_ten;
          pos_d               = pos_q + 4'd1;
          started_d           = started_q || show;
          if (last_pos) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (load) begin
      y_d       = YW'(q_data_i.fix);
      pos_d     = 4'd0;
      started_d = 1'b0;
      prec_d    = q_data_i.prec;
      state_d   = q_data_i.neg ? StSign : StDigit;
    end
    if (!emit) begin
      out_req_d = out_req_q;
    end
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q       <= y_d;
    pos_q     <= pos_d;
    started_q <= started_d;
    prec_q    <= prec_d;
    out_req_q <= out_req_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule
